// ===== rtl/srt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srt_pkg: shared types and constants for the sorted record table
// Command and status codes, table sizing and the front-to-back command beat.
// ---------------------------------------------------------------------------
package srt_pkg;

   localparam int Depth     = 32;
   localparam int IdBits    = 16;
   localparam int AddrBits  = $clog2(Depth);
   localparam int CountBits = $clog2(Depth + 1);
   localparam int QDepth    = 2;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   // command beat from front to back
   typedef struct packed {
      cmd_type            cmd;
      logic [IdBits-1:0]  id;
      logic [7:0]         month;
      logic [63:0]        value;
      logic [4:0]         index;
   } cmd_beat_type;

endpackage : srt_pkg
`default_nettype wire

// ===== rtl/srt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srt_front: command intake queue
// Accepts request beats, masks the id and holds them for the back end.
// ---------------------------------------------------------------------------
module srt_front
   import srt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [1:0]   req_cmd,
   input  wire logic [15:0]  req_owner_id,
   input  wire logic [7:0]   req_month,
   input  wire logic [63:0]  req_value_word,
   input  wire logic [4:0]   req_read_index,
   output logic              q_valid,
   input  wire logic         q_take,
   output cmd_beat_type      q_beat
);

   localparam int PtrBits = $clog2(QDepth);

   cmd_beat_type         slot_ff [QDepth];
   logic [PtrBits-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]     cnt_ff, cnt_in;
   logic                 do_push, do_pop;
   cmd_beat_type         beat;

   assign full    = (cnt_ff == (PtrBits+1)'(QDepth));
   assign q_valid = (cnt_ff != '0);
   assign q_beat  = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = q_take && q_valid;

   // classify and pack the incoming beat
   always_comb begin
      beat.cmd   = cmd_type'(req_cmd);
      beat.id    = req_owner_id[IdBits-1:0];
      beat.month = req_month;
      beat.value = req_value_word;
      beat.index = req_read_index;
   end

   // pointer update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= beat;
      end
   end

endmodule : srt_front
`default_nettype wire

// ===== rtl/srt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// srt_back: table engine
// Walks the record memory one entry per cycle to search and compact, moves
// each entry to shift by a read then a write, and leaves one result beat in an output register.
// ---------------------------------------------------------------------------
module srt_back
   import srt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   output logic               q_take,
   input  wire cmd_beat_type  q_beat,
   output logic               empty,
   input  wire logic          pop,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_out_id,
   output logic [7:0]         rsp_out_month,
   output logic [63:0]        rsp_out_value,
   output logic [5:0]         rsp_entry_count
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_SHIFT  = 7'b0000100,
      S_PLACE  = 7'b0001000,
      S_COMP   = 7'b0010000,
      S_READ   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   localparam int RecBits = IdBits + 8 + 64;

   // record memory, one entry per record
   logic [RecBits-1:0]   mem [Depth];
   logic [RecBits-1:0]   rdata_ff;
   logic [AddrBits-1:0]  raddr;
   logic                 we;
   logic [AddrBits-1:0]  waddr;
   logic [RecBits-1:0]   wdata;

   state_type            state_ff, state_in;
   cmd_beat_type         cur_ff, cur_in;
   logic [CountBits-1:0] used_ff, used_in;
   logic [CountBits-1:0] i_ff, i_in;     // read cursor
   logic [CountBits-1:0] w_ff, w_in;     // write cursor / insert place
   logic                 rv_ff, rv_in;   // rdata_ff holds entry i_ff-1
   logic                 hit_ff, hit_in;
   logic [CountBits-1:0] hpos_ff, hpos_in;
   logic [CountBits-1:0] gpos_ff, gpos_in;
   logic                 gfound_ff, gfound_in;
   logic                 ovalid_ff, ovalid_in;
   status_type           ost_ff, ost_in;
   logic [RecBits-1:0]   orec_ff, orec_in;
   logic [CountBits-1:0] ocnt_ff;

   logic [IdBits-1:0]    r_id;
   logic [7:0]           r_month;
   logic [IdBits+7:0]    r_key, c_key;

   assign r_id    = rdata_ff[RecBits-1 -: IdBits];
   assign r_month = rdata_ff[71:64];
   assign r_key   = {r_id, r_month};
   assign c_key   = {cur_ff.id, cur_ff.month};

   assign empty           = !ovalid_ff;
   assign rsp_status      = ost_ff;
   assign rsp_out_id      = 16'(orec_ff[RecBits-1 -: IdBits]);
   assign rsp_out_month   = orec_ff[71:64];
   assign rsp_out_value   = orec_ff[63:0];
   assign rsp_entry_count = 6'(ocnt_ff);
   assign q_take          = (state_ff == S_IDLE) && q_valid && !ovalid_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      used_in   = used_ff;
      i_in      = i_ff;
      w_in      = w_ff;
      rv_in     = 1'b0;
      hit_in    = hit_ff;
      hpos_in   = hpos_ff;
      gpos_in   = gpos_ff;
      gfound_in = gfound_ff;
      ovalid_in = ovalid_ff && !pop;
      ost_in    = ost_ff;
      orec_in   = orec_ff;
      raddr     = i_ff[AddrBits-1:0];
      we        = 1'b0;
      waddr     = w_ff[AddrBits-1:0];
      wdata     = rdata_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_take) begin
               cur_in    = q_beat;
               i_in      = '0;
               w_in      = '0;
               hit_in    = 1'b0;
               gfound_in = 1'b0;
               orec_in   = '0;
               ost_in    = ST_OK;
               state_in  = (q_beat.cmd == CMD_READ) ? S_READ :
                           (q_beat.cmd == CMD_DELETE) ? S_COMP : S_SCAN;
            end
         end
         // linear search for pair and insert place
         S_SCAN: begin
            if (rv_ff) begin
               if (r_key == c_key && !hit_ff) begin
                  hit_in  = 1'b1;
                  hpos_in = i_ff - 1'b1;
               end
               if (r_key > c_key && !gfound_ff) begin
                  gfound_in = 1'b1;
                  gpos_in   = i_ff - 1'b1;
               end
            end
            if (i_ff < used_ff) begin
               rv_in = 1'b1;
               i_in  = i_ff + 1'b1;
            end else if (!rv_ff) begin
               // scan finished
               if (cur_ff.cmd == CMD_UPDATE) begin
                  if (hit_ff) begin
                     we       = 1'b1;
                     waddr    = hpos_ff[AddrBits-1:0];
                     wdata    = {cur_ff.id, cur_ff.month, cur_ff.value};
                  end else begin
                     ost_in   = ST_NOT_FOUND;
                  end
                  state_in = S_DONE;
               end else if (hit_ff) begin
                  ost_in   = ST_DUPLICATE;
                  state_in = S_DONE;
               end else if (used_ff >= CountBits'(Depth)) begin
                  ost_in   = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  w_in     = gfound_ff ? gpos_ff : used_ff;
                  i_in     = used_ff;
                  state_in = S_SHIFT;
               end
            end
         end
         // move entries up by one, from the top down
         S_SHIFT: begin
            if (rv_ff) begin
               we    = 1'b1;
               waddr = i_ff[AddrBits-1:0];
               wdata = rdata_ff;
            end
            if (!rv_ff && i_ff > w_ff) begin
               raddr = AddrBits'(i_ff - 1'b1);
               rv_in = 1'b1;
            end else if (rv_ff) begin
               i_in = i_ff - 1'b1;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            we       = 1'b1;
            waddr    = w_ff[AddrBits-1:0];
            wdata    = {cur_ff.id, cur_ff.month, cur_ff.value};
            used_in  = used_ff + 1'b1;
            state_in = S_DONE;
         end
         // compact away every record of the id
         S_COMP: begin
            if (rv_ff && r_id != cur_ff.id) begin
               we    = 1'b1;
               waddr = w_ff[AddrBits-1:0];
               wdata = rdata_ff;
               w_in  = w_ff + 1'b1;
            end
            if (i_ff < used_ff) begin
               rv_in = 1'b1;
               i_in  = i_ff + 1'b1;
            end else if (!rv_ff) begin
               if (w_ff == used_ff) ost_in = ST_NOT_FOUND;
               used_in  = w_ff;
               state_in = S_DONE;
            end
         end
         S_READ: begin
            raddr = cur_ff.index[AddrBits-1:0];
            if (rv_ff) begin
               orec_in  = rdata_ff;
               state_in = S_DONE;
            end else if (CountBits'(cur_ff.index) < used_ff) begin
               rv_in = 1'b1;
            end else begin
               ost_in   = ST_RANGE;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            ovalid_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         used_ff   <= '0;
         ovalid_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         ovalid_ff <= ovalid_in;
         rv_ff     <= rv_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      i_ff      <= i_in;
      w_ff      <= w_in;
      hit_ff    <= hit_in;
      hpos_ff   <= hpos_in;
      gpos_ff   <= gpos_in;
      gfound_ff <= gfound_in;
      ost_ff    <= ost_in;
      orec_ff   <= orec_in;
      if (state_ff == S_DONE) ocnt_ff <= used_ff;
   end

   // record memory ports
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CountBits'(Depth)) else $error("count above depth");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |=> state_ff != S_IDLE) else $error("take without start");
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !pop) |=> ovalid_ff && $stable(ost_ff))
      else $error("result beat lost");
`endif

endmodule : srt_back
`default_nettype wire

// ===== rtl/sorted_record_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_record_table: table of records kept in id, month order
// Commands run one at a time through the engine. Update, delete and a refused
// insert walk the single record memory one entry per cycle; an insert that
// goes in also moves each entry above its place up by one, a read then a
// write through the one port pair per entry. A two-beat queue holds commands
// ahead of the engine and a result register holds the finished beat; the
// engine starts no new command until that beat is popped.
// ---------------------------------------------------------------------------
module sorted_record_table
   import srt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [1:0]   req_cmd,
   input  wire logic [15:0]  req_owner_id,
   input  wire logic [7:0]   req_month,
   input  wire logic [63:0]  req_value_word,
   input  wire logic [4:0]   req_read_index,
   output logic              empty,
   input  wire logic         pop,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_out_id,
   output logic [7:0]        rsp_out_month,
   output logic [63:0]       rsp_out_value,
   output logic [5:0]        rsp_entry_count
);

   logic         q_valid, q_take;
   cmd_beat_type q_beat;

   // command intake
   srt_front u_front (
      .clock, .reset, .push, .full,
      .req_cmd, .req_owner_id, .req_month, .req_value_word, .req_read_index,
      .q_valid, .q_take, .q_beat
   );

   // table engine
   srt_back u_back (
      .clock, .reset, .q_valid, .q_take, .q_beat, .empty, .pop,
      .rsp_status, .rsp_out_id, .rsp_out_month, .rsp_out_value,
      .rsp_entry_count
   );

endmodule : sorted_record_table
`default_nettype wire
